// ===== rtl/core/gpzmp_pkg.sv =====
// shared types, constants and helpers for the gait phase zmp estimator
package gpzmp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WORD_WIDTH = 32;

    // configuration bus geometry
    localparam int PDATA_W = (WORD_WIDTH > 32) ? 64 : 32;
    localparam int PADDR_W = (WORD_WIDTH > 32) ? 4 : 3;
    localparam int TOL_W   = 16;

    // register indexes
    localparam logic REG_FLOOR_HEIGHT = 1'b0;
    localparam logic REG_MIDPOINT_TOL = 1'b1;

    // floor height at reset: round(-0.630 * 2^FRAC_BITS)
    localparam longint FLOOR_RESET_L = -(((longint'(63) << FRAC_BITS) + 50) / 100);
    localparam logic signed [WORD_WIDTH-1:0] FLOOR_RESET = WORD_WIDTH'(FLOOR_RESET_L);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    // gait phase codes
    localparam logic [1:0] PH_STANDING    = 2'd0;
    localparam logic [1:0] PH_LEFT_SWING  = 2'd1;
    localparam logic [1:0] PH_RIGHT_SWING = 2'd2;

    // divider steps: integer and fractional quotient bits
    localparam int DIV_STEPS = WORD_WIDTH + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic                         start;
        logic signed [WORD_WIDTH-1:0] torque;
        logic signed [WORD_WIDTH-1:0] fz;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic                       zero;
        logic signed [WORD_WIDTH:0] term;
    } div_rsp_t;

    // clamp to the signed word range
    function automatic logic signed [WORD_WIDTH-1:0] sat_word(
        input logic signed [WORD_WIDTH+2:0] v
    );
        logic signed [WORD_WIDTH+2:0] wmax;
        logic signed [WORD_WIDTH+2:0] wmin;
        wmax = (WORD_WIDTH+3)'({1'b0, {(WORD_WIDTH-1){1'b1}}});
        wmin = -wmax - (WORD_WIDTH+3)'(1);
        if (v > wmax)
        begin
            sat_word = wmax[WORD_WIDTH-1:0];
        end
        else if (v < wmin)
        begin
            sat_word = wmin[WORD_WIDTH-1:0];
        end
        else
        begin
            sat_word = v[WORD_WIDTH-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/gpzmp_div.sv =====
// serial restoring divider for the torque over force term, one quotient bit a cycle
module gpzmp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  gpzmp_pkg::div_req_t req,
    output gpzmp_pkg::div_rsp_t rsp
);
    import gpzmp_pkg::*;

    typedef enum logic [3:0] {
        DV_IDLE = 4'b0001,
        DV_RUN  = 4'b0010,
        DV_FIX  = 4'b0100,
        DV_DONE = 4'b1000
    } dv_state_t;

    dv_state_t                  state_reg, state_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [WORD_WIDTH-1:0]      dvd_reg, dvd_next;
    logic [WORD_WIDTH-1:0]      nf_reg, nf_next;
    logic [WORD_WIDTH-1:0]      rem_reg, rem_next;
    logic [WORD_WIDTH:0]        q_reg, q_next;
    logic                       ovf_reg, ovf_next;
    logic                       neg_reg, neg_next;
    logic                       tneg_reg, tneg_next;
    logic                       zero_reg, zero_next;
    logic signed [WORD_WIDTH:0] term_reg, term_next;

    logic [WORD_WIDTH-1:0]      t_abs, f_abs;
    logic [WORD_WIDTH-1:0]      shifted;
    logic [WORD_WIDTH:0]        diff;
    logic                       qbit;
    logic [WORD_WIDTH-1:0]      limit;
    logic [WORD_WIDTH-1:0]      mag;

    assign t_abs   = req.torque[WORD_WIDTH-1] ? (~req.torque + 1'b1) : req.torque;
    assign f_abs   = req.fz[WORD_WIDTH-1] ? (~req.fz + 1'b1) : req.fz;
    assign shifted = {rem_reg[WORD_WIDTH-2:0], dvd_reg[WORD_WIDTH-1]};
    assign diff    = {1'b0, shifted} - {1'b0, nf_reg};
    assign qbit    = ~diff[WORD_WIDTH];
    // largest magnitude the signed word holds for this sign
    assign limit   = neg_reg ? {1'b1, {(WORD_WIDTH-1){1'b0}}}
                             : {1'b0, {(WORD_WIDTH-1){1'b1}}};
    assign mag     = (ovf_reg || (q_reg > {1'b0, limit})) ? limit : q_reg[WORD_WIDTH-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        nf_next    = nf_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        neg_next   = neg_reg;
        tneg_next  = tneg_reg;
        zero_next  = zero_reg;
        term_next  = term_reg;
        unique case (state_reg)
            DV_IDLE:
            begin
                if (req.start)
                begin
                    dvd_next  = t_abs;
                    nf_next   = f_abs;
                    rem_next  = '0;
                    q_next    = '0;
                    ovf_next  = 1'b0;
                    cnt_next  = '0;
                    neg_next  = req.torque[WORD_WIDTH-1] ^ req.fz[WORD_WIDTH-1];
                    tneg_next = req.torque[WORD_WIDTH-1];
                    zero_next = (req.fz == '0);
                    state_next = (req.fz == '0) ? DV_FIX : DV_RUN;
                end
            end
            DV_RUN:
            begin
                rem_next = qbit ? diff[WORD_WIDTH-1:0] : shifted;
                dvd_next = {dvd_reg[WORD_WIDTH-2:0], 1'b0};
                q_next   = {q_reg[WORD_WIDTH-1:0], qbit};
                ovf_next = ovf_reg | q_reg[WORD_WIDTH];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = DV_FIX;
                end
            end
            DV_FIX:
            begin
                if (zero_reg)
                begin
                    // zero force: rail by the torque sign
                    term_next = tneg_reg ? $signed({2'b11, {(WORD_WIDTH-1){1'b0}}})
                                         : $signed({2'b00, {(WORD_WIDTH-1){1'b1}}});
                end
                else
                begin
                    term_next = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                end
                state_next = DV_DONE;
            end
            DV_DONE:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        nf_reg   <= nf_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        neg_reg  <= neg_next;
        tneg_reg <= tneg_next;
        zero_reg <= zero_next;
        term_reg <= term_next;
    end

    assign rsp.done = (state_reg == DV_DONE);
    assign rsp.zero = zero_reg;
    assign rsp.term = term_reg;

endmodule

// ===== rtl/core/gait_phase_zmp_estimator.sv =====
// top level of the gait phase zmp estimator: capture, phase tracking, sequencer, output register
// divisions: two per item in a swing phase, four while standing, all on the single serial
//   divider (48 quotient bits, one a cycle); a division with zero force skips the quotient bits
// the input stalls until the item in flight has been handed to the output register, so a new
//   item is taken only after the last one is through
// reset: asynchronous, active low; phase standing, no previous zmp seen, registers at defaults
module gait_phase_zmp_estimator (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // configuration port
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [gpzmp_pkg::PADDR_W-1:0]             paddr,
    input  logic [gpzmp_pkg::PDATA_W-1:0]             pwdata,
    output logic [gpzmp_pkg::PDATA_W-1:0]             prdata,
    output logic                                      pready,
    // input channel
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   desired_zmp_x,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   desired_zmp_y,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   right_foot_x,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   right_foot_y,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   left_foot_x,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   left_foot_y,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   right_force_z,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   right_torque_x,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   right_torque_y,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   left_force_z,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   left_torque_x,
    input  logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   left_torque_y,
    // output channel
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   estimated_zmp_x,
    output logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   estimated_zmp_y,
    output logic signed [gpzmp_pkg::WORD_WIDTH-1:0]   estimated_zmp_z,
    output logic [1:0]                                gait_phase,
    output logic                                      zero_force_flag
);
    import gpzmp_pkg::*;

    localparam int OFF_W = WORD_WIDTH + 2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_OFFS  = 6'b000010,
        S_PHASE = 6'b000100,
        S_DIV   = 6'b001000,
        S_WAIT  = 6'b010000,
        S_FINAL = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [WORD_WIDTH-1:0] floor_height_reg;
    logic [TOL_W-1:0]             tol_reg;
    logic                         cfg_write;
    logic                         cfg_index;

    // sample capture
    logic signed [WORD_WIDTH-1:0] dx_reg, dy_reg, rfx_reg, rfy_reg, lfx_reg, lfy_reg;
    logic signed [WORD_WIDTH-1:0] fzr_reg, txr_reg, tyr_reg, fzl_reg, txl_reg, tyl_reg;

    // gait state
    logic [1:0]                   phase_reg, phase_next;
    logic signed [WORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic                         first_seen_reg;
    logic                         change_reg;
    logic signed [OFF_W-1:0]      offx_reg, offy_reg;

    // sequencer and accumulation
    logic [1:0]                   job_reg, job_next;
    logic signed [OFF_W-1:0]      acc_x_reg, acc_x_next;
    logic signed [OFF_W-1:0]      acc_y_reg, acc_y_next;
    logic                         zf_reg, zf_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic signed [WORD_WIDTH-1:0] est_x_reg, est_y_reg, est_z_reg;
    logic [1:0]                   phase_out_reg;
    logic                         zf_out_reg;

    logic                         in_xfer, out_xfer, out_free;
    logic                         standing;
    logic                         use_right;
    logic                         last_job;
    logic signed [OFF_W-1:0]      tol2;
    logic                         at_mid;
    logic [1:0]                   swing_phase;
    logic signed [OFF_W-1:0]      term_ext;
    logic signed [OFF_W-1:0]      sub_x, sub_y;
    logic signed [OFF_W:0]        ex_wide, ey_wide;

    div_req_t div_req;
    div_rsp_t div_rsp;

    gpzmp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // configuration port: zero wait states, index from the word address
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[PADDR_W-1];

    always_comb
    begin
        unique case (cfg_index)
            REG_FLOOR_HEIGHT: prdata = PDATA_W'(floor_height_reg);
            REG_MIDPOINT_TOL: prdata = PDATA_W'(tol_reg);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_height_reg <= FLOOR_RESET;
            tol_reg          <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FLOOR_HEIGHT: floor_height_reg <= $signed(pwdata[WORD_WIDTH-1:0]);
                REG_MIDPOINT_TOL: tol_reg          <= pwdata[TOL_W-1:0];
                default:          tol_reg          <= tol_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshakes: one item in flight, result waits in its own register
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid & ~in_stall;
    assign out_xfer = out_valid_reg & ~out_stall;
    assign out_free = ~out_valid_reg | ~out_stall;

    // ------------------------------------------------------------------
    // phase tracking
    // ------------------------------------------------------------------
    // phase code three never arises; it counts as standing
    assign standing = (phase_reg != PH_LEFT_SWING) && (phase_reg != PH_RIGHT_SWING);

    // |2*desired - a - b| < 2*tolerance on both axes, written as two signed bounds
    assign tol2   = $signed({{(OFF_W-TOL_W-1){1'b0}}, tol_reg, 1'b0});
    assign at_mid = (offx_reg < tol2) && (offx_reg > -tol2)
                 && (offy_reg < tol2) && (offy_reg > -tol2);

    always_comb
    begin
        priority if (phase_reg == PH_LEFT_SWING)
        begin
            swing_phase = PH_RIGHT_SWING;
        end
        else if (phase_reg == PH_RIGHT_SWING)
        begin
            swing_phase = PH_LEFT_SWING;
        end
        else
        begin
            // from standing: side of the midpoint, tie goes to right swing
            swing_phase = offy_reg[OFF_W-1] ? PH_LEFT_SWING : PH_RIGHT_SWING;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (state_reg == S_PHASE && change_reg)
        begin
            phase_next = at_mid ? PH_STANDING : swing_phase;
        end
    end

    // ------------------------------------------------------------------
    // division jobs: bit 0 picks the axis (y torque, then x torque),
    // bit 1 the second foot; swing runs the support foot only
    // ------------------------------------------------------------------
    assign use_right = (phase_reg == PH_LEFT_SWING) || (standing && job_reg[1]);
    assign last_job  = standing ? (job_reg == 2'd3) : (job_reg == 2'd1);

    always_comb
    begin
        div_req.start = (state_reg == S_DIV);
        if (use_right)
        begin
            div_req.fz     = fzr_reg;
            div_req.torque = job_reg[0] ? txr_reg : tyr_reg;
        end
        else
        begin
            div_req.fz     = fzl_reg;
            div_req.torque = job_reg[0] ? txl_reg : tyl_reg;
        end
    end

    assign term_ext = OFF_W'(div_rsp.term);

    // final combine: mean of both feet while standing, floor of the half sum
    assign sub_x   = standing ? (acc_x_reg >>> 1) : acc_x_reg;
    assign sub_y   = standing ? (acc_y_reg >>> 1) : acc_y_reg;
    assign ex_wide = (OFF_W+1)'(dx_reg) - (OFF_W+1)'(sub_x);
    assign ey_wide = (OFF_W+1)'(dy_reg) + (OFF_W+1)'(sub_y);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        acc_x_next     = acc_x_reg;
        acc_y_next     = acc_y_reg;
        zf_next        = zf_reg;
        out_valid_next = out_valid_reg;
        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    job_next   = '0;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    zf_next    = 1'b0;
                    state_next = S_OFFS;
                end
            end
            S_OFFS:
            begin
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (job_reg[0])
                    begin
                        acc_y_next = acc_y_reg + term_ext;
                    end
                    else
                    begin
                        acc_x_next = acc_x_reg + term_ext;
                    end
                    zf_next  = zf_reg | div_rsp.zero;
                    job_next = job_reg + 1'b1;
                    state_next = last_job ? S_FINAL : S_DIV;
                end
            end
            S_FINAL:
            begin
                // hold until the output register is empty or being taken
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_STANDING;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            first_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            job_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            job_reg       <= job_next;
            if (state_reg == S_OFFS)
            begin
                prev_x_reg     <= dx_reg;
                prev_y_reg     <= dy_reg;
                first_seen_reg <= 1'b1;
            end
        end
    end

    // sample capture and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            dx_reg  <= desired_zmp_x;
            dy_reg  <= desired_zmp_y;
            rfx_reg <= right_foot_x;
            rfy_reg <= right_foot_y;
            lfx_reg <= left_foot_x;
            lfy_reg <= left_foot_y;
            fzr_reg <= right_force_z;
            txr_reg <= right_torque_x;
            tyr_reg <= right_torque_y;
            fzl_reg <= left_force_z;
            txl_reg <= left_torque_x;
            tyl_reg <= left_torque_y;
        end
        if (state_reg == S_OFFS)
        begin
            // the first sample only loads the previous zmp
            change_reg <= first_seen_reg && ((dx_reg != prev_x_reg) || (dy_reg != prev_y_reg));
            offx_reg   <= (OFF_W'(dx_reg) <<< 1) - OFF_W'(rfx_reg) - OFF_W'(lfx_reg);
            offy_reg   <= (OFF_W'(dy_reg) <<< 1) - OFF_W'(rfy_reg) - OFF_W'(lfy_reg);
        end
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        zf_reg    <= zf_next;
        if (state_reg == S_FINAL && out_free)
        begin
            est_x_reg     <= sat_word(ex_wide);
            est_y_reg     <= sat_word(ey_wide);
            est_z_reg     <= floor_height_reg;
            phase_out_reg <= phase_reg;
            zf_out_reg    <= zf_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign estimated_zmp_x = est_x_reg;
    assign estimated_zmp_y = est_y_reg;
    assign estimated_zmp_z = est_z_reg;
    assign gait_phase      = phase_out_reg;
    assign zero_force_flag = zf_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a division result only turns up while the sequencer waits for one
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_WAIT))
        else $error("divider result outside wait state");

    // a swing phase never runs the second foot's jobs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT && !standing) |-> !job_reg[1])
        else $error("second foot division during swing");

    // a finished item reaches the output register and the block goes idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINAL && out_free) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not loaded into output register");

    // the phase only moves during the phase update step
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_PHASE) |=> $stable(phase_reg))
        else $error("gait phase changed outside update step");

endmodule

// ===== test/zmp_estimate_checker.sv =====
// scoreboard for the gait phase zmp estimator: register tracking, estimate prediction, comparison
module zmp_estimate_checker
    import gpzmp_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [PADDR_W-1:0]             paddr,
    input  logic [PDATA_W-1:0]             pwdata,
    input  logic                           pready,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic signed [WORD_WIDTH-1:0]   desired_zmp_x,
    input  logic signed [WORD_WIDTH-1:0]   desired_zmp_y,
    input  logic signed [WORD_WIDTH-1:0]   right_foot_x,
    input  logic signed [WORD_WIDTH-1:0]   right_foot_y,
    input  logic signed [WORD_WIDTH-1:0]   left_foot_x,
    input  logic signed [WORD_WIDTH-1:0]   left_foot_y,
    input  logic signed [WORD_WIDTH-1:0]   right_force_z,
    input  logic signed [WORD_WIDTH-1:0]   right_torque_x,
    input  logic signed [WORD_WIDTH-1:0]   right_torque_y,
    input  logic signed [WORD_WIDTH-1:0]   left_force_z,
    input  logic signed [WORD_WIDTH-1:0]   left_torque_x,
    input  logic signed [WORD_WIDTH-1:0]   left_torque_y,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [WORD_WIDTH-1:0]   estimated_zmp_x,
    input  logic signed [WORD_WIDTH-1:0]   estimated_zmp_y,
    input  logic signed [WORD_WIDTH-1:0]   estimated_zmp_z,
    input  logic [1:0]                     gait_phase,
    input  logic                           zero_force_flag,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [WORD_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t      zmp_x;
        word_t      zmp_y;
        word_t      zmp_z;
        logic [1:0] phase;
        logic       zero_force;
    } estimate_t;

    localparam longint TERM_MAX = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
    localparam longint TERM_MIN = -TERM_MAX - 1;

    word_t            floor_height_q;
    logic [TOL_W-1:0] tolerance_q;
    logic [1:0]       phase_q;
    longint           last_zmp_x;
    longint           last_zmp_y;
    bit               sample_seen;
    estimate_t        expected_estimates[$];

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic word_t clamp_word(input longint v);
        if (v > TERM_MAX)
        begin
            return word_t'(TERM_MAX);
        end
        if (v < TERM_MIN)
        begin
            return word_t'(TERM_MIN);
        end
        return word_t'(v);
    endfunction

    // torque over force in fixed point, truncated towards zero and clamped
    function automatic longint lever_arm(input longint torque, input longint force_z,
                                         inout bit zero_seen);
        longint unsigned num;
        longint unsigned den;
        longint unsigned limit;
        longint unsigned quot;
        bit              negative;
        if (force_z == 0)
        begin
            zero_seen = 1'b1;
            return (torque < 0) ? TERM_MIN : TERM_MAX;
        end
        negative = (torque < 0) != (force_z < 0);
        num      = magnitude(torque);
        den      = magnitude(force_z);
        limit    = negative ? TERM_MAX + 1 : TERM_MAX;
        quot     = (num << FRAC_BITS) / den;
        if (quot > limit)
        begin
            quot = limit;
        end
        return negative ? -longint'(quot) : longint'(quot);
    endfunction

    // phase update and estimate for the sample on the input ports
    function automatic estimate_t next_estimate();
        longint    dx;
        longint    dy;
        longint    off_x;
        longint    off_y;
        longint    tol2;
        longint    qxl;
        longint    qyl;
        longint    qxr;
        longint    qyr;
        longint    ex;
        longint    ey;
        bit        zero_seen;
        estimate_t est;
        dx        = desired_zmp_x;
        dy        = desired_zmp_y;
        zero_seen = 1'b0;
        if (sample_seen && (dx != last_zmp_x || dy != last_zmp_y))
        begin
            off_x = 2 * dx - (longint'(right_foot_x) + longint'(left_foot_x));
            off_y = 2 * dy - (longint'(right_foot_y) + longint'(left_foot_y));
            case (phase_q)
                PH_LEFT_SWING:  phase_q = PH_RIGHT_SWING;
                PH_RIGHT_SWING: phase_q = PH_LEFT_SWING;
                default:        phase_q = (off_y < 0) ? PH_LEFT_SWING : PH_RIGHT_SWING;
            endcase
            tol2 = 2 * longint'(tolerance_q);
            if (magnitude(off_x) < tol2 && magnitude(off_y) < tol2)
            begin
                phase_q = PH_STANDING;
            end
        end
        last_zmp_x  = dx;
        last_zmp_y  = dy;
        sample_seen = 1'b1;

        case (phase_q)
            PH_RIGHT_SWING:
            begin
                ex = dx - lever_arm(left_torque_y, left_force_z, zero_seen);
                ey = dy + lever_arm(left_torque_x, left_force_z, zero_seen);
            end
            PH_LEFT_SWING:
            begin
                ex = dx - lever_arm(right_torque_y, right_force_z, zero_seen);
                ey = dy + lever_arm(right_torque_x, right_force_z, zero_seen);
            end
            default:
            begin
                qyl = lever_arm(left_torque_y, left_force_z, zero_seen);
                qyr = lever_arm(right_torque_y, right_force_z, zero_seen);
                qxl = lever_arm(left_torque_x, left_force_z, zero_seen);
                qxr = lever_arm(right_torque_x, right_force_z, zero_seen);
                ex  = dx - ((qyl + qyr) >>> 1);
                ey  = dy + ((qxl + qxr) >>> 1);
            end
        endcase

        est.zmp_x      = clamp_word(ex);
        est.zmp_y      = clamp_word(ey);
        est.zmp_z      = floor_height_q;
        est.phase      = phase_q;
        est.zero_force = zero_seen;
        return est;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        estimate_t want;
        if (!rst_n)
        begin
            floor_height_q = FLOOR_RESET;
            tolerance_q    = TOL_RESET;
            phase_q        = PH_STANDING;
            last_zmp_x     = 0;
            last_zmp_y     = 0;
            sample_seen    = 1'b0;
            fail_count     = 0;
            expected_estimates.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_FLOOR_HEIGHT)
                begin
                    floor_height_q = pwdata[WORD_WIDTH-1:0];
                end
                else if (paddr[2] == REG_MIDPOINT_TOL)
                begin
                    tolerance_q = pwdata[TOL_W-1:0];
                end
            end

            // older estimates leave before a new sample is predicted
            if (out_valid && !out_stall)
            begin
                if (expected_estimates.size() == 0)
                begin
                    $error("estimate transfer with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_estimates.pop_front();
                    if (estimated_zmp_x !== want.zmp_x)
                    begin
                        $error("estimated_zmp_x: expected %0d, got %0d",
                               want.zmp_x, estimated_zmp_x);
                        fail_count++;
                    end
                    if (estimated_zmp_y !== want.zmp_y)
                    begin
                        $error("estimated_zmp_y: expected %0d, got %0d",
                               want.zmp_y, estimated_zmp_y);
                        fail_count++;
                    end
                    if (estimated_zmp_z !== want.zmp_z)
                    begin
                        $error("estimated_zmp_z: expected %0d, got %0d",
                               want.zmp_z, estimated_zmp_z);
                        fail_count++;
                    end
                    if (gait_phase !== want.phase)
                    begin
                        $error("gait_phase: expected %0d, got %0d", want.phase, gait_phase);
                        fail_count++;
                    end
                    if (zero_force_flag !== want.zero_force)
                    begin
                        $error("zero_force_flag: expected %0d, got %0d",
                               want.zero_force, zero_force_flag);
                        fail_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                expected_estimates.insert(expected_estimates.size(), next_estimate());
            end
            pending <= expected_estimates.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
// testbench top: drives samples and register writes into the zmp estimator and gives the verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gpzmp_pkg::*;

    typedef logic signed [WORD_WIDTH-1:0] word_t;

    // one sample as it crosses the input channel, in port order
    typedef struct packed {
        word_t desired_zmp_x;
        word_t desired_zmp_y;
        word_t right_foot_x;
        word_t right_foot_y;
        word_t left_foot_x;
        word_t left_foot_y;
        word_t right_force_z;
        word_t right_torque_x;
        word_t right_torque_y;
        word_t left_force_z;
        word_t left_torque_x;
        word_t left_torque_y;
    } sample_t;

    localparam int    SAMPLE_WORDS    = $bits(sample_t) / WORD_WIDTH;
    localparam word_t WORD_MAX        = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN        = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam word_t BODY_LOAD       = word_t'(300 << FRAC_BITS);
    localparam word_t SMALL_MOMENT    = word_t'(2 << FRAC_BITS);
    localparam word_t LARGE_MOMENT    = word_t'(100 << FRAC_BITS);
    localparam word_t FOOT_HALF_GAP   = word_t'(6554);
    localparam int    MAX_IDLE        = 19;
    localparam int    PHASES          = 5;
    localparam int    ITEMS_PER_PHASE = 200;
    localparam int    STRETCH         = 40;
    // covers the four divisions of a standing sample, plus margin
    localparam int    END_PAUSE       = 250;
    // longest correct silence is one standing sample plus a full output stall
    localparam int    QUIET_LIMIT     = 2000;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [PADDR_W-1:0]   paddr          = '0;
    logic [PDATA_W-1:0]   pwdata         = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    word_t                desired_zmp_x  = '0;
    word_t                desired_zmp_y  = '0;
    word_t                right_foot_x   = '0;
    word_t                right_foot_y   = '0;
    word_t                left_foot_x    = '0;
    word_t                left_foot_y    = '0;
    word_t                right_force_z  = '0;
    word_t                right_torque_x = '0;
    word_t                right_torque_y = '0;
    word_t                left_force_z   = '0;
    word_t                left_torque_x  = '0;
    word_t                left_torque_y  = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    word_t                estimated_zmp_x;
    word_t                estimated_zmp_y;
    word_t                estimated_zmp_z;
    logic [1:0]           gait_phase;
    logic                 zero_force_flag;
    int                   fail_count;
    int                   pending;

    // shared by both sides: zero gives a stretch of back-to-back transfers
    int unsigned          idle_max       = MAX_IDLE;
    // tolerance the generator aims its near-midpoint samples at
    int unsigned          mid_tol        = TOL_RESET;
    // desired zmp of the last sample sent, so a sequence can hold it
    word_t                held_zmp_x     = '0;
    word_t                held_zmp_y     = '0;
    int unsigned          quiet_cycles   = 0;

    gait_phase_zmp_estimator DUT (.*);

    zmp_estimate_checker checker_i (.*);

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // watchdog: any channel transfer counts as progress
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // output side: a fresh random hold before every result transfer
    initial
    begin
        int unsigned hold;
        forever
        begin
            hold = $urandom_range(0, idle_max);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    function automatic longint jitter(input int unsigned span);
        return longint'($urandom_range(0, 2 * span)) - longint'(span);
    endfunction

    function automatic word_t corner_word();
        case ($urandom_range(0, 4))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return word_t'(1);
            3:       return word_t'(-1);
            default: return '0;
        endcase
    endfunction

    // mostly a realistic body load, with unloaded, inverted and extreme feet mixed in
    function automatic word_t pick_force();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            return '0;
        end
        if (sel < 12)
        begin
            return corner_word();
        end
        if (sel < 22)
        begin
            return word_t'($urandom);
        end
        if (sel < 27)
        begin
            return -word_t'($urandom_range(1 << FRAC_BITS, 800 << FRAC_BITS));
        end
        return word_t'($urandom_range(20 << FRAC_BITS, 800 << FRAC_BITS));
    endfunction

    function automatic word_t pick_torque();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
        begin
            return corner_word();
        end
        if (sel < 20)
        begin
            return word_t'($urandom);
        end
        return word_t'(jitter(60 << FRAC_BITS));
    endfunction

    // walking-like samples with random content; about one in seven is pure noise
    function automatic sample_t random_sample();
        sample_t                          s;
        logic [SAMPLE_WORDS*WORD_WIDTH-1:0] raw;
        longint                           base_x;
        longint                           base_y;
        longint                           spread;
        longint                           mid_x;
        longint                           mid_y;
        int unsigned                      mode;
        int                               i;
        mode = $urandom_range(0, 99);
        if (mode < 15)
        begin
            raw = '0;
            for (i = 0; i < SAMPLE_WORDS; i++)
            begin
                raw = {raw[(SAMPLE_WORDS-1)*WORD_WIDTH-1:0], word_t'($urandom)};
            end
            s = raw;
            return s;
        end

        base_x         = jitter(1 << FRAC_BITS);
        base_y         = jitter(1 << FRAC_BITS);
        spread         = $urandom_range(3000, 10000);
        s.right_foot_x = word_t'(base_x + jitter(FOOT_HALF_GAP));
        s.left_foot_x  = word_t'(base_x + jitter(FOOT_HALF_GAP));
        s.right_foot_y = word_t'(base_y - spread);
        // the tie band needs an even sum of the feet y so the midpoint is exact
        s.left_foot_y  = word_t'(base_y + spread + ((mode >= 55 && mode < 60) ? 0
                                                    : $urandom_range(0, 1)));
        mid_x = (longint'(s.right_foot_x) + longint'(s.left_foot_x)) >>> 1;
        mid_y = (longint'(s.right_foot_y) + longint'(s.left_foot_y)) >>> 1;

        if (mode < 35)
        begin
            // hold the desired zmp: no phase step
            s.desired_zmp_x = held_zmp_x;
            s.desired_zmp_y = held_zmp_y;
        end
        else if (mode < 55)
        begin
            // around the tolerance window, both sides of its edge
            s.desired_zmp_x = word_t'(mid_x + jitter(mid_tol + 2));
            s.desired_zmp_y = word_t'(mid_y + jitter(mid_tol + 2));
        end
        else if (mode < 60)
        begin
            // y exactly on the midpoint, x off it
            s.desired_zmp_x = word_t'(longint'(s.right_foot_x) + 20000);
            s.desired_zmp_y = word_t'(mid_y);
        end
        else if (mode < 85)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                s.desired_zmp_x = word_t'(longint'(s.right_foot_x) + jitter(2000));
                s.desired_zmp_y = word_t'(longint'(s.right_foot_y) + jitter(2000));
            end
            else
            begin
                s.desired_zmp_x = word_t'(longint'(s.left_foot_x) + jitter(2000));
                s.desired_zmp_y = word_t'(longint'(s.left_foot_y) + jitter(2000));
            end
        end
        else
        begin
            s.desired_zmp_x = word_t'(jitter(2 << FRAC_BITS));
            s.desired_zmp_y = word_t'(jitter(2 << FRAC_BITS));
        end

        s.right_force_z  = pick_force();
        s.right_torque_x = pick_torque();
        s.right_torque_y = pick_torque();
        s.left_force_z   = pick_force();
        s.left_torque_x  = pick_torque();
        s.left_torque_y  = pick_torque();
        return s;
    endfunction

    // one input transfer after a random gap; valid stays up when the gap is zero
    task automatic push_sample(input sample_t s);
        int unsigned gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        desired_zmp_x  <= s.desired_zmp_x;
        desired_zmp_y  <= s.desired_zmp_y;
        right_foot_x   <= s.right_foot_x;
        right_foot_y   <= s.right_foot_y;
        left_foot_x    <= s.left_foot_x;
        left_foot_y    <= s.left_foot_y;
        right_force_z  <= s.right_force_z;
        right_torque_x <= s.right_torque_x;
        right_torque_y <= s.right_torque_y;
        left_force_z   <= s.left_force_z;
        left_torque_x  <= s.left_torque_x;
        left_torque_y  <= s.left_torque_y;
        held_zmp_x      = s.desired_zmp_x;
        held_zmp_y      = s.desired_zmp_y;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // directed sample with the feet 0.1 m either side of the origin
    task automatic send_directed(input word_t dzx, input word_t dzy,
                                 input word_t fzr, input word_t txr, input word_t tyr,
                                 input word_t fzl, input word_t txl, input word_t tyl);
        sample_t s;
        s.desired_zmp_x  = dzx;
        s.desired_zmp_y  = dzy;
        s.right_foot_x   = '0;
        s.right_foot_y   = -FOOT_HALF_GAP;
        s.left_foot_x    = '0;
        s.left_foot_y    = FOOT_HALF_GAP;
        s.right_force_z  = fzr;
        s.right_torque_x = txr;
        s.right_torque_y = tyr;
        s.left_force_z   = fzl;
        s.left_torque_x  = txl;
        s.left_torque_y  = tyl;
        push_sample(s);
    endtask

    task automatic send_uniform(input word_t v);
        push_sample({SAMPLE_WORDS{v}});
    endtask

    // drop valid and wait until every estimate has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // setup then access cycle; the write lands on the edge with pready high
    task automatic write_register(input logic index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        word_t       floor_setting[PHASES];
        int unsigned tol_setting[PHASES];
        int          p;
        int          n;

        floor_setting = '{WORD_MIN, WORD_MAX, word_t'($urandom), '0, word_t'($urandom)};
        tol_setting   = '{0, 65535, $urandom_range(1, 16), 1, $urandom_range(0, 65535)};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, registers at their reset values (tolerance of one lsb)
        // first sample only loads the previous desired zmp: stays standing
        send_directed(3277, -3000, BODY_LOAD, SMALL_MOMENT, -SMALL_MOMENT,
                      BODY_LOAD, -SMALL_MOMENT, SMALL_MOMENT);
        // unchanged desired zmp with both feet unloaded: terms saturate, flag raised
        send_directed(3277, -3000, '0, SMALL_MOMENT, -SMALL_MOMENT, '0, '0, -SMALL_MOMENT);
        // y below the midpoint: left swing, support term saturates on a one-lsb force
        send_directed(1000, -5000, 1, WORD_MIN, WORD_MAX, BODY_LOAD, '0, '0);
        // alternation to right swing, force of minus one against the most negative torques
        send_directed(1000, 5000, BODY_LOAD, '0, '0, -1, WORD_MIN, WORD_MIN);
        // back onto the midpoint: standing
        send_directed(0, 0, BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT,
                      BODY_LOAD, -SMALL_MOMENT, SMALL_MOMENT);
        // y exactly on the midpoint with x well away: sign tie goes to right swing
        send_directed(65536, 0, BODY_LOAD, SMALL_MOMENT, '0, BODY_LOAD, '0, SMALL_MOMENT);
        // left swing with the support foot unloaded
        send_directed(65536, 3000, '0, SMALL_MOMENT, -SMALL_MOMENT,
                      BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT);
        // right swing, most negative force and torques on the support foot
        send_directed(-65536, 3000, BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT,
                      WORD_MIN, WORD_MIN, WORD_MIN);
        // offsets landing exactly on the tolerance bound do not count as midpoint
        send_directed(1, 0, BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT,
                      BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT);
        send_directed(0, 1, BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT,
                      BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT);
        send_directed(0, 0, BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT,
                      BODY_LOAD, SMALL_MOMENT, SMALL_MOMENT);
        // desired zmp at the top of the range, correction pushes past it: clamped
        send_directed(WORD_MAX, WORD_MAX, BODY_LOAD, '0, '0,
                      BODY_LOAD, LARGE_MOMENT, -LARGE_MOMENT);
        // and at the bottom, with the other foot supporting
        send_directed(WORD_MIN, WORD_MIN, BODY_LOAD, -LARGE_MOMENT, LARGE_MOMENT,
                      BODY_LOAD, '0, '0);
        // every field at once at its extremes, zero and minus one
        send_uniform(WORD_MAX);
        send_uniform(WORD_MIN);
        send_uniform('0);
        send_uniform(-1);
        // standing, odd negative sum of terms rounds down on halving
        send_directed(-1, -1, 1 << FRAC_BITS, '0, '0, 1 << FRAC_BITS, '0, -3);
        // standing with one foot unloaded
        send_directed(-1, -1, '0, -SMALL_MOMENT, SMALL_MOMENT,
                      BODY_LOAD, SMALL_MOMENT, -SMALL_MOMENT);
        // fractional quotient truncated towards zero in both signs
        send_directed(2000, -4000, 3, -1, 1, 3, -1, 1);

        // random phases, each under its own register setting
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            write_register(REG_FLOOR_HEIGHT, floor_setting[p]);
            write_register(REG_MIDPOINT_TOL, tol_setting[p]);
            mid_tol = tol_setting[p];
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % STRETCH == 0)
                begin
                    idle_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
                end
                push_sample(random_sample());
            end
        end

        // let any stray result show up before the verdict
        drain();
        repeat (END_PAUSE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/gpzmp_pkg.sv
rtl/core/gpzmp_div.sv
rtl/core/gait_phase_zmp_estimator.sv
test/zmp_estimate_checker.sv
test/testbench.sv
